### src/column_statistics_reducer_assert.svh
// assertion macros used by the column statistics reducer controller
// depends on nothing; the controller includes it by bare file name
`ifndef COLUMN_STATISTICS_REDUCER_ASSERT_SVH
`define COLUMN_STATISTICS_REDUCER_ASSERT_SVH

// same-cycle implication
`define CSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/csr_pkg.sv
// shared types and constants of the column statistics reducer
// depends on nothing
package csr_pkg;

    localparam int MAX_ROWS_DEF      = 1048576;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int DIV_BITS          = 192;
    localparam int DIV_CNT_W         = 8;
    localparam int STEP_W            = 4;

    localparam logic [STEP_W-1:0] FIN_LAST_STEP = 4'd8;

    localparam logic [1:0] CFG_STAT_SELECT  = 2'd0;
    localparam logic [1:0] CFG_DROP_MISSING = 2'd1;
    localparam logic [1:0] CFG_MISSING_CODE = 2'd2;

    localparam logic [2:0] STAT_MIN  = 3'd0;
    localparam logic [2:0] STAT_MAX  = 3'd1;
    localparam logic [2:0] STAT_SUM  = 3'd2;
    localparam logic [2:0] STAT_PROD = 3'd3;
    localparam logic [2:0] STAT_MEAN = 3'd4;
    localparam logic [2:0] STAT_VAR  = 3'd5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PROD_LO,
        OP_PROD_HI,
        OP_SQUARE,
        OP_ACCUM,
        OP_MEAN_LOAD,
        OP_FIN_MUL,
        OP_FIN_ADD,
        OP_DIV_START,
        OP_OUT_LOAD
    } op_t;

    typedef enum logic [1:0] {
        FIN_DIRECT,
        FIN_MEAN,
        FIN_VAR
    } fin_kind_t;

    typedef struct packed {
        logic              load;
        op_t               op;
        logic [STEP_W-1:0] step;
    } csr_cmd_t;

    typedef struct packed {
        logic      accum;
        logic      last;
        fin_kind_t kind;
        logic      div_done;
        logic      out_free;
    } csr_status_t;

endpackage

### src/csr_divider.sv
// restoring bit-serial divider with round-to-nearest and signed saturation
// depends on csr_pkg
module csr_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [csr_pkg::DIV_BITS-1:0] num,
    input  logic [63:0]                  den,
    input  logic                         neg,
    output logic                         done,
    output logic signed [63:0]           quo,
    output logic                         ovf
);

    typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_ROUND} dv_state_t;

    dv_state_t                      state_reg;
    logic [csr_pkg::DIV_BITS-1:0]   num_reg;
    logic [63:0]                    den_reg;
    logic                           neg_reg;
    logic [63:0]                    rem_reg;
    logic [63:0]                    q_reg;
    logic                           of_reg;
    logic [csr_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           done_reg;
    logic signed [63:0]             quo_reg;
    logic                           ovf_reg;

    logic [63:0] rem_shift;
    logic        ge;
    logic        round_up;
    logic        q_full;
    logic [63:0] q_round;
    logic        of_round;
    logic [63:0] limit;
    logic        sat;
    logic [63:0] mag;

    always_comb begin
        rem_shift = {rem_reg[62:0], num_reg[csr_pkg::DIV_BITS-1]};
        ge        = rem_shift >= den_reg;
        round_up  = rem_reg >= (den_reg - rem_reg);
        q_full    = &q_reg;
        q_round   = q_reg + {63'd0, round_up && !q_full};
        of_round  = of_reg || (round_up && q_full);
        limit     = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        sat       = of_round || (q_round > limit);
        mag       = sat ? limit : q_round;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else if (start) begin
            num_reg   <= num;
            den_reg   <= den;
            neg_reg   <= neg;
            rem_reg   <= '0;
            q_reg     <= '0;
            of_reg    <= 1'b0;
            cnt_reg   <= csr_pkg::DIV_CNT_W'(csr_pkg::DIV_BITS - 1);
            done_reg  <= 1'b0;
            state_reg <= DV_RUN;
        end else begin
            unique case (state_reg)
                DV_IDLE: begin
                end
                DV_RUN: begin
                    num_reg <= num_reg << 1;
                    rem_reg <= ge ? (rem_shift - den_reg) : rem_shift;
                    q_reg   <= {q_reg[62:0], ge};
                    if (q_reg[63]) begin
                        of_reg <= 1'b1;
                    end
                    if (cnt_reg == '0) begin
                        state_reg <= DV_ROUND;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                DV_ROUND: begin
                    quo_reg   <= neg_reg ? -$signed(mag) : $signed(mag);
                    ovf_reg   <= sat;
                    done_reg  <= 1'b1;
                    state_reg <= DV_IDLE;
                end
                default: begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule

### src/csr_ctrl.sv
// controller state machine of the column statistics reducer
// depends on csr_pkg and column_statistics_reducer_assert.svh
`include "column_statistics_reducer_assert.svh"

module csr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  csr_pkg::csr_status_t status,
    output csr_pkg::csr_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_PLO, ST_PHI, ST_SQ, ST_ACC, ST_FIN,
        ST_FMUL, ST_FADD, ST_DIVGO, ST_DIV, ST_OUT
    } state_t;

    state_t                         state_reg, state_next;
    logic [csr_pkg::STEP_W-1:0]     step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.op     = csr_pkg::OP_NONE;
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.accum) begin
                    state_next = ST_PLO;
                end else if (status.last) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PLO: begin
                cmd.op     = csr_pkg::OP_PROD_LO;
                state_next = ST_PHI;
            end
            ST_PHI: begin
                cmd.op     = csr_pkg::OP_PROD_HI;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.op     = csr_pkg::OP_SQUARE;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op     = csr_pkg::OP_ACCUM;
                state_next = status.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                unique case (status.kind)
                    csr_pkg::FIN_MEAN: begin
                        cmd.op     = csr_pkg::OP_MEAN_LOAD;
                        state_next = ST_DIVGO;
                    end
                    csr_pkg::FIN_VAR: begin
                        step_next  = '0;
                        state_next = ST_FMUL;
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_FMUL: begin
                cmd.op     = csr_pkg::OP_FIN_MUL;
                state_next = ST_FADD;
            end
            ST_FADD: begin
                cmd.op = csr_pkg::OP_FIN_ADD;
                if (step_reg == csr_pkg::FIN_LAST_STEP) begin
                    state_next = ST_DIVGO;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_FMUL;
                end
            end
            ST_DIVGO: begin
                cmd.op     = csr_pkg::OP_DIV_START;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.op     = csr_pkg::OP_OUT_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `CSR_ASSERT_IMP(a_out_slot_free, aclk, aresetn, cmd.op == csr_pkg::OP_OUT_LOAD,
        status.out_free, "result loaded over a pending result")
    `CSR_ASSERT_NXT(a_div_wait, aclk, aresetn, cmd.op == csr_pkg::OP_DIV_START,
        state_reg == ST_DIV, "divider started without waiting for it")
    `CSR_ASSERT_IMP(a_idle_quiet, aclk, aresetn, s_ready,
        cmd.op == csr_pkg::OP_NONE, "datapath command issued while taking requests")

endmodule

### src/csr_datapath.sv
// datapath: config registers, accumulators, shared multiplier, divider, output register
// depends on csr_pkg and csr_divider
module csr_datapath #(
    parameter int MAX_ROWS      = csr_pkg::MAX_ROWS_DEF,
    parameter int FRACTION_BITS = csr_pkg::FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic signed [31:0]   s_value,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [63:0]   m_result,
    output logic                 m_has_value,
    output logic                 m_is_missing,
    output logic                 m_overflow,
    input  csr_pkg::csr_cmd_t    cmd,
    output csr_pkg::csr_status_t status
);

    localparam int CW = $clog2(MAX_ROWS + 1);

    logic [2:0]          stat_reg;
    logic                drop_reg;
    logic signed [31:0]  code_reg;

    logic signed [31:0]  value_reg;
    logic                last_reg;
    logic                accum_reg;

    logic signed [31:0]  ext_reg;
    logic signed [63:0]  sum_reg;
    logic [127:0]        sumsq_reg;
    logic signed [63:0]  prod_reg;
    logic [CW-1:0]       count_reg;
    logic                saw_reg;
    logic                psat_reg;

    logic [63:0]         p_reg;
    logic [63:0]         plo_reg;
    logic [127:0]        acc_reg;
    logic [63:0]         den_reg;
    logic                neg_reg;

    logic                out_valid_reg;
    logic signed [63:0]  out_result_reg;
    logic                out_has_reg;
    logic                out_miss_reg;
    logic                out_ovf_reg;

    logic [31:0]  vm;
    logic [63:0]  pm;
    logic [63:0]  sum_mag;
    logic [31:0]  n32;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  mul_p;
    logic [95:0]  prod_full;
    logic         prod_neg;
    logic [63:0]  prod_limit;
    logic         prod_sat;
    logic [63:0]  prod_mag;
    logic [127:0] fin_term;
    logic         v_wins;

    csr_pkg::fin_kind_t kind;
    logic signed [63:0] d_result;
    logic               d_has;
    logic               d_miss;
    logic               d_ovf;
    logic signed [63:0] code64;

    logic [csr_pkg::DIV_BITS-1:0] div_num;
    logic                         div_done;
    logic signed [63:0]           div_quo;
    logic                         div_ovf;

    always_comb begin
        vm      = value_reg[31] ? 32'(-value_reg) : 32'(value_reg);
        pm      = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        sum_mag = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);
        n32     = 32'(count_reg);
        code64  = {{32{code_reg[31]}}, code_reg};
        div_num = {64'd0, acc_reg} << FRACTION_BITS;
    end

    // shared 32x32 multiplier operand select
    always_comb begin
        mul_a = vm;
        mul_b = vm;
        case (cmd.op)
            csr_pkg::OP_PROD_LO: begin
                mul_a = pm[31:0];
            end
            csr_pkg::OP_PROD_HI: begin
                mul_a = pm[63:32];
            end
            csr_pkg::OP_FIN_MUL: begin
                case (cmd.step)
                    4'd0: begin mul_a = sumsq_reg[31:0];   mul_b = n32; end
                    4'd1: begin mul_a = sumsq_reg[63:32];  mul_b = n32; end
                    4'd2: begin mul_a = sumsq_reg[95:64];  mul_b = n32; end
                    4'd3: begin mul_a = sumsq_reg[127:96]; mul_b = n32; end
                    4'd4: begin mul_a = sum_mag[31:0];     mul_b = sum_mag[31:0]; end
                    4'd5: begin mul_a = sum_mag[63:32];    mul_b = sum_mag[31:0]; end
                    4'd6: begin mul_a = sum_mag[31:0];     mul_b = sum_mag[63:32]; end
                    4'd7: begin mul_a = sum_mag[63:32];    mul_b = sum_mag[63:32]; end
                    default: begin mul_a = n32;            mul_b = n32 - 32'd1; end
                endcase
            end
            default: begin
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // product combine and saturation, min/max comparison
    always_comb begin
        prod_full  = {p_reg, 32'd0} + {32'd0, plo_reg};
        prod_neg   = prod_reg[63] ^ value_reg[31];
        prod_limit = prod_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        prod_sat   = (|prod_full[95:64]) || (prod_full[63:0] > prod_limit);
        prod_mag   = prod_sat ? prod_limit : prod_full[63:0];
        v_wins     = (stat_reg == csr_pkg::STAT_MAX) ? (value_reg > ext_reg)
                                                     : (value_reg < ext_reg);
    end

    // partial product placed at its word offset
    always_comb begin
        case (cmd.step)
            4'd0:          fin_term = {64'd0, p_reg};
            4'd1:          fin_term = {32'd0, p_reg, 32'd0};
            4'd2:          fin_term = {p_reg, 64'd0};
            4'd3:          fin_term = {p_reg[31:0], 96'd0};
            4'd4:          fin_term = {64'd0, p_reg};
            4'd5, 4'd6:    fin_term = {32'd0, p_reg, 32'd0};
            default:       fin_term = {p_reg, 64'd0};
        endcase
    end

    // column end decision
    always_comb begin
        kind     = csr_pkg::FIN_DIRECT;
        d_result = '0;
        d_has    = count_reg != '0;
        d_miss   = 1'b0;
        d_ovf    = 1'b0;
        if (saw_reg && !drop_reg) begin
            d_result = code64;
            d_has    = 1'b1;
            d_miss   = 1'b1;
        end else begin
            unique case (stat_reg) inside
                csr_pkg::STAT_MIN, csr_pkg::STAT_MAX: begin
                    d_result = (count_reg != '0) ? 64'(ext_reg) : 64'sd0;
                end
                csr_pkg::STAT_SUM: begin
                    d_result = sum_reg;
                end
                csr_pkg::STAT_PROD: begin
                    d_result = prod_reg;
                    d_ovf    = psat_reg;
                end
                csr_pkg::STAT_MEAN: begin
                    if (count_reg == '0) begin
                        d_result = code64;
                        d_miss   = 1'b1;
                    end else begin
                        kind = csr_pkg::FIN_MEAN;
                    end
                end
                csr_pkg::STAT_VAR: begin
                    if (count_reg < CW'(2)) begin
                        d_result = code64;
                        d_miss   = 1'b1;
                    end else begin
                        kind = csr_pkg::FIN_VAR;
                    end
                end
                default: begin
                    d_has  = 1'b0;
                    d_miss = 1'b1;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_reg <= csr_pkg::STAT_MIN;
            drop_reg <= 1'b0;
            code_reg <= 32'sh8000_0000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                csr_pkg::CFG_STAT_SELECT:  stat_reg <= cfg_data[2:0];
                csr_pkg::CFG_DROP_MISSING: drop_reg <= cfg_data[0];
                csr_pkg::CFG_MISSING_CODE: code_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // column accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= 1'b0;
            last_reg  <= 1'b0;
            ext_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            prod_reg  <= 64'sd1;
            count_reg <= '0;
            saw_reg   <= 1'b0;
            psat_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                value_reg <= s_value;
                last_reg  <= s_last;
                if (s_value == code_reg) begin
                    saw_reg   <= 1'b1;
                    accum_reg <= 1'b0;
                end else begin
                    accum_reg <= count_reg < CW'(MAX_ROWS);
                end
            end
            unique case (cmd.op)
                csr_pkg::OP_SQUARE: begin
                    prod_reg <= (prod_neg && prod_mag != '0) ? -$signed(prod_mag)
                                                             : $signed(prod_mag);
                    if (prod_sat) begin
                        psat_reg <= 1'b1;
                    end
                end
                csr_pkg::OP_ACCUM: begin
                    if (count_reg == '0 || v_wins) begin
                        ext_reg <= value_reg;
                    end
                    sum_reg   <= sum_reg + 64'(value_reg);
                    sumsq_reg <= sumsq_reg + {64'd0, p_reg};
                    count_reg <= count_reg + 1'b1;
                end
                csr_pkg::OP_OUT_LOAD: begin
                    ext_reg   <= '0;
                    sum_reg   <= '0;
                    sumsq_reg <= '0;
                    prod_reg  <= 64'sd1;
                    count_reg <= '0;
                    saw_reg   <= 1'b0;
                    psat_reg  <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // multiplier and finishing registers
    always_ff @(posedge aclk) begin
        p_reg <= mul_p;
        if (cmd.op == csr_pkg::OP_PROD_HI) begin
            plo_reg <= p_reg;
        end
        if (cmd.op == csr_pkg::OP_MEAN_LOAD) begin
            acc_reg <= {64'd0, sum_mag};
            den_reg <= 64'(count_reg);
            neg_reg <= sum_reg[63];
        end
        if (cmd.op == csr_pkg::OP_FIN_ADD) begin
            case (cmd.step)
                4'd0:          acc_reg <= {64'd0, p_reg};
                4'd1, 4'd2, 4'd3:
                               acc_reg <= acc_reg + fin_term;
                4'd4, 4'd5, 4'd6, 4'd7:
                               acc_reg <= acc_reg - fin_term;
                default: begin
                    den_reg <= p_reg;
                    neg_reg <= 1'b0;
                end
            endcase
        end
    end

    csr_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == csr_pkg::OP_DIV_START),
        .num     (div_num),
        .den     (den_reg),
        .neg     (neg_reg),
        .done    (div_done),
        .quo     (div_quo),
        .ovf     (div_ovf)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == csr_pkg::OP_OUT_LOAD) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.op == csr_pkg::OP_OUT_LOAD) begin
            if (kind == csr_pkg::FIN_DIRECT) begin
                out_result_reg <= d_result;
                out_has_reg    <= d_has;
                out_miss_reg   <= d_miss;
                out_ovf_reg    <= d_ovf;
            end else begin
                out_result_reg <= div_quo;
                out_has_reg    <= 1'b1;
                out_miss_reg   <= 1'b0;
                out_ovf_reg    <= div_ovf;
            end
        end
    end

    assign cfg_ready    = 1'b1;
    assign m_valid      = out_valid_reg;
    assign m_result     = out_result_reg;
    assign m_has_value  = out_has_reg;
    assign m_is_missing = out_miss_reg;
    assign m_overflow   = out_ovf_reg;

    assign status.accum    = accum_reg;
    assign status.last     = last_reg;
    assign status.kind     = kind;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || m_ready;

endmodule

### src/column_statistics_reducer.sv
// column statistics reducer: takes one signed column element per request and
// gives one statistic (min, max, sum, product, mean or variance) at the column end.
// an element that accumulates passes accept, decide, then four steps: the two
// halves of the 64x32 product and the square through the single shared 32x32
// multiplier, then the update; a missing or overlong element passes only accept
// and decide. at the last element, min/max/sum/product results are loaded
// directly; mean uses the 192-step bit-serial divider, and variance first runs
// nine multiply/accumulate pairs forming n*sumsq - sum^2 and divisor n*(n-1).
// a finished result sits in an output register; the next column can start
// while it waits, and only the next result load waits for it to be taken.
// depends on csr_pkg, csr_ctrl, csr_datapath, csr_divider
module column_statistics_reducer #(
    parameter int MAX_ROWS      = csr_pkg::MAX_ROWS_DEF,
    parameter int FRACTION_BITS = csr_pkg::FRACTION_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // element requests
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_value,
    input  logic                s_last,
    // result requests
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [63:0]  m_result,
    output logic                m_has_value,
    output logic                m_is_missing,
    output logic                m_overflow
);

    // command and status between controller and datapath
    csr_pkg::csr_cmd_t    cmd;
    csr_pkg::csr_status_t status;

    csr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    csr_datapath #(
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_value      (s_value),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result     (m_result),
        .m_has_value  (m_has_value),
        .m_is_missing (m_is_missing),
        .m_overflow   (m_overflow),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
